// ----- rtl/tlfe_pkg.sv -----
// tlfe_pkg: shared types and constants for the tank level and flow estimator
// used by tlfe_arith and tank_level_flow_estimator; no dependencies
package tlfe_pkg;

    localparam int RING_DEPTH = 8;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W      = 24 + SLOT_W;

    localparam logic [23:0] RATE_MAX   = 24'hFFFFFF;
    localparam logic [38:0] CLPH_SCALE = 39'd360000000000;
    localparam logic [21:0] PI_Q20     = 22'd3294199;
    localparam logic [19:0] US_PER_S   = 20'd1000000;

    // reciprocals of the decimal-point divisors in Q36, exact for 26-bit dividends
    localparam logic [36:0] DOT_RECIP_1    = 37'd68719476736;
    localparam logic [36:0] DOT_RECIP_10   = 37'd6871947674;
    localparam logic [36:0] DOT_RECIP_100  = 37'd687194768;
    localparam logic [36:0] DOT_RECIP_1000 = 37'd68719477;

    // volume divisor 4000000 * 2^20 = 2^28 * 15625; reciprocal of 15625 in Q44
    localparam logic [30:0] VOL_RECIP  = 31'd1125899907;
    // quotient by 2^28 at which the volume saturates (65536 * 15625)
    localparam logic [29:0] VOL_SAT_Q  = 30'd1024000000;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_UNCHANGED = 3'd1,
        ST_READ_FAIL = 3'd2,
        ST_RANGE     = 3'd3,
        ST_TICK      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CFG_UNIT     = 3'd0,
        CFG_DOT      = 3'd1,
        CFG_DIAM     = 3'd2,
        CFG_MAX      = 3'd3,
        CFG_RATE_LIM = 3'd4,
        CFG_STALE    = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MM,
        S_VD,
        S_VM,
        S_VP,
        S_VQ,
        S_ODEC,
        S_OMUL,
        S_ODIV,
        S_IDEC,
        S_IMUL,
        S_IDIV,
        S_STALE1,
        S_STALE2,
        S_DONE
    } state_t;

endpackage

// ----- rtl/tlfe_arith.sv -----
// tlfe_arith: shared bit-serial 64-bit multiplier and restoring divider
// one bit per cycle; depends on tlfe_pkg
module tlfe_arith (
    input  logic               clk,
    input  logic               rst_n,
    input  tlfe_pkg::arith_req_t req,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic               done,
    output logic [63:0]        result
);
    import tlfe_pkg::*;

    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [64:0] acc_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    arith_op_t   op_reg;
    logic [64:0] rem_sh;

    assign rem_sh = {acc_reg[63:0], x_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= a;
            y_reg   <= b;
            acc_reg <= '0;
            op_reg  <= req.op;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (y_reg[0])
                        acc_reg <= acc_reg + {1'b0, x_reg};
                    x_reg <= {x_reg[62:0], 1'b0};
                    y_reg <= {1'b0, y_reg[63:1]};
                end
                OP_DIV:
                begin
                    if (rem_sh >= {1'b0, y_reg})
                    begin
                        acc_reg <= rem_sh - {1'b0, y_reg};
                        x_reg   <= {x_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= rem_sh;
                        x_reg   <= {x_reg[62:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? acc_reg[63:0] : x_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("arith done without a running operation");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("arith started while busy");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 6'd63 && !req.start) |=> !busy_reg && done)
        else $error("arith did not finish after 64 steps");

endmodule

// ----- rtl/tank_level_flow_estimator.sv -----
// tank_level_flow_estimator: level scaling, cylinder volume, flow rate rings
// depends on tlfe_pkg and tlfe_arith
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | opcode, read_ok, raw_level, time_us
//  out     | out_valid / out_stall| status, level_mm, volume_l, avg_*_clph
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// from acceptance to the result load, a read failure or tick uses no
// arithmetic; out of range, unchanged level or zero diameter stop after the
// scale reciprocal; a changed level runs the operations of the one bit-serial
// unit in turn (scale reciprocal, three volume products, volume reciprocal, and a
// product plus divide for the one rate that can move in a transaction)
// in_stall is high from acceptance until the result is loaded into the
// output register; one finished result may wait there while the next
// transaction is accepted. reset clears the stored state and rings at once
module tank_level_flow_estimator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  opcode,
    input  logic [0:0]  read_ok,
    input  logic [15:0] raw_level,
    input  logic [47:0] time_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] level_mm,
    output logic [15:0] volume_l,
    output logic [23:0] avg_outflow_clph,
    output logic [23:0] avg_inflow_clph,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tlfe_pkg::*;

    // configuration
    logic [7:0]  unit_reg;
    logic [1:0]  dot_reg;
    logic [11:0] diam_reg;
    logic [15:0] max_reg;
    logic [15:0] rlim_reg;
    logic [15:0] stale_reg;

    // sequencer and transaction
    state_t      state_reg, state_next;
    logic        tick_reg;
    logic [47:0] now_reg;
    logic [15:0] mm_reg;
    logic [15:0] vol_reg;
    logic        low_reg;
    status_t     st_reg;
    logic [47:0] dt_reg;
    logic [35:0] prod_reg;

    // stored state
    logic [15:0] level_reg;
    logic [15:0] volume_reg;
    logic [15:0] oref_vol_reg, iref_vol_reg;
    logic [47:0] oref_time_reg, iref_time_reg;
    logic [47:0] opush_reg, ipush_reg;
    logic [23:0] oring_reg [RING_DEPTH];
    logic [23:0] iring_reg [RING_DEPTH];
    logic [SLOT_W-1:0] oslot_reg, islot_reg;
    logic [SUM_W-1:0]  osum_reg, isum_reg;

    // output register
    logic        ovalid_reg;
    status_t     ostatus_reg;
    logic [15:0] olevel_reg, ovolume_reg;
    logic [23:0] oavg_o_reg, oavg_i_reg;

    // shared unit
    arith_req_t  ar_req;
    logic [63:0] ar_a, ar_b, ar_res;
    logic        ar_done;

    tlfe_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ar_req),
        .a      (ar_a),
        .b      (ar_b),
        .done   (ar_done),
        .result (ar_res)
    );

    logic        accept;
    logic [25:0] scaled;
    logic [36:0] dot_recip;
    logic [27:0] mm_q;
    logic [35:0] vq_in;
    logic [29:0] vq_clamp;
    logic [47:0] dt_o, dt_i;
    logic [19:0] vq;
    logic [15:0] vol_sat;
    logic [23:0] rate_sat;
    logic [48:0] lim_o, lim_i;
    logic        push_o, push_i;
    logic [23:0] pval_o, pval_i;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        unique case (unit_reg)
            8'd1, 8'd17: scaled = 26'(raw_level) * 26'd10;
            8'd2:        scaled = 26'(raw_level);
            default:     scaled = 26'(raw_level) * 26'd1000;
        endcase
        unique case (dot_reg)
            2'd1:    dot_recip = DOT_RECIP_10;
            2'd2:    dot_recip = DOT_RECIP_100;
            2'd3:    dot_recip = DOT_RECIP_1000;
            default: dot_recip = DOT_RECIP_1;
        endcase
    end

    // scaled level is the Q36 product shifted down
    assign mm_q     = ar_res[63:36];
    // volume product shifted by 2^28, clamped where the litres saturate anyway
    assign vq_in    = ar_res[63:28];
    assign vq_clamp = (vq_in >= 36'(VOL_SAT_Q)) ? VOL_SAT_Q : vq_in[29:0];
    assign vq       = ar_res[63:44];
    assign dt_o     = now_reg - oref_time_reg;
    assign dt_i     = now_reg - iref_time_reg;
    assign vol_sat  = (|vq[19:16]) ? 16'hFFFF : vq[15:0];
    assign rate_sat = (|ar_res[63:24]) ? RATE_MAX : ar_res[23:0];
    assign lim_o    = {1'b0, opush_reg} + 49'(prod_reg);
    assign lim_i    = {1'b0, ipush_reg} + 49'(prod_reg);

    // sequencer: next state, shared unit requests and ring pushes
    always_comb
    begin
        state_next = state_reg;
        ar_req.start = 1'b0;
        ar_req.op    = OP_MUL;
        ar_a = '0;
        ar_b = '0;
        push_o = 1'b0;
        push_i = 1'b0;
        pval_o = '0;
        pval_i = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == 1'b1)
                        state_next = S_STALE1;
                    else if (read_ok == 1'b0 || raw_level == 16'd0)
                        state_next = S_DONE;
                    else
                    begin
                        ar_req.start = 1'b1;
                        ar_a = 64'(scaled);
                        ar_b = 64'(dot_recip);
                        state_next = S_MM;
                    end
                end
            end
            S_MM:
            begin
                if (ar_done)
                begin
                    if ((|mm_q[27:16]) || mm_q[15:0] > max_reg)
                        state_next = S_DONE;
                    else if (mm_q[15:0] == level_reg)
                        state_next = S_STALE1;
                    else if (diam_reg == 12'd0)
                        state_next = S_STALE1;
                    else
                    begin
                        ar_req.start = 1'b1;
                        ar_a = 64'(diam_reg);
                        ar_b = 64'(diam_reg);
                        state_next = S_VD;
                    end
                end
            end
            S_VD:
            begin
                if (ar_done)
                begin
                    ar_req.start = 1'b1;
                    ar_a = ar_res;
                    ar_b = 64'(mm_reg);
                    state_next = S_VM;
                end
            end
            S_VM:
            begin
                if (ar_done)
                begin
                    ar_req.start = 1'b1;
                    ar_a = ar_res;
                    ar_b = 64'(PI_Q20);
                    state_next = S_VP;
                end
            end
            S_VP:
            begin
                if (ar_done)
                begin
                    ar_req.start = 1'b1;
                    ar_a = 64'(vq_clamp);
                    ar_b = 64'(VOL_RECIP);
                    state_next = S_VQ;
                end
            end
            S_VQ:
            begin
                if (ar_done)
                    state_next = S_ODEC;
            end
            S_ODEC:
            begin
                state_next = S_IDEC;
                if (vol_reg < oref_vol_reg && low_reg)
                begin
                    if (dt_o == 48'd0)
                    begin
                        push_o = 1'b1;
                        pval_o = RATE_MAX;
                    end
                    else
                    begin
                        ar_req.start = 1'b1;
                        ar_a = 64'(oref_vol_reg - vol_reg);
                        ar_b = 64'(CLPH_SCALE);
                        state_next = S_OMUL;
                    end
                end
            end
            S_OMUL:
            begin
                if (ar_done)
                begin
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_DIV;
                    ar_a = ar_res;
                    ar_b = 64'(dt_reg);
                    state_next = S_ODIV;
                end
            end
            S_ODIV:
            begin
                if (ar_done)
                begin
                    push_o = 1'b1;
                    pval_o = rate_sat;
                    state_next = S_IDEC;
                end
            end
            S_IDEC:
            begin
                state_next = S_STALE1;
                if (iref_vol_reg != 16'd0 && vol_reg > iref_vol_reg && low_reg)
                begin
                    if (dt_i == 48'd0)
                    begin
                        push_i = 1'b1;
                        pval_i = RATE_MAX;
                    end
                    else
                    begin
                        ar_req.start = 1'b1;
                        ar_a = 64'(vol_reg - iref_vol_reg);
                        ar_b = 64'(CLPH_SCALE);
                        state_next = S_IMUL;
                    end
                end
            end
            S_IMUL:
            begin
                if (ar_done)
                begin
                    ar_req.start = 1'b1;
                    ar_req.op    = OP_DIV;
                    ar_a = ar_res;
                    ar_b = 64'(dt_reg);
                    state_next = S_IDIV;
                end
            end
            S_IDIV:
            begin
                if (ar_done)
                begin
                    push_i = 1'b1;
                    pval_i = rate_sat;
                    state_next = S_STALE1;
                end
            end
            S_STALE1:
                state_next = S_STALE2;
            S_STALE2:
            begin
                // zero push when the last push is older than the timeout
                push_o = (lim_o < {1'b0, now_reg});
                push_i = (lim_i < {1'b0, now_reg});
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg  <= 8'd0;
            dot_reg   <= 2'd0;
            diam_reg  <= 12'd0;
            max_reg   <= 16'd3500;
            rlim_reg  <= 16'd2800;
            stale_reg <= 16'd3600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT:     unit_reg  <= cfg_data[7:0];
                CFG_DOT:      dot_reg   <= cfg_data[1:0];
                CFG_DIAM:     diam_reg  <= cfg_data[11:0];
                CFG_MAX:      max_reg   <= cfg_data;
                CFG_RATE_LIM: rlim_reg  <= cfg_data;
                CFG_STALE:    stale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // transaction datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg  <= time_us;
            tick_reg <= opcode[0];
            st_reg   <= (opcode == 1'b1) ? ST_TICK :
                        (read_ok == 1'b0 || raw_level == 16'd0) ? ST_READ_FAIL :
                        ST_UPDATED;
        end
        if (state_reg == S_MM && ar_done)
        begin
            mm_reg  <= mm_q[15:0];
            low_reg <= mm_q[15:0] < rlim_reg;
            if ((|mm_q[27:16]) || mm_q[15:0] > max_reg)
                st_reg <= ST_RANGE;
            else if (mm_q[15:0] == level_reg)
                st_reg <= ST_UNCHANGED;
        end
        if (state_reg == S_VQ && ar_done)
            vol_reg <= vol_sat;
        if (state_reg == S_ODEC)
            dt_reg <= dt_o;
        if (state_reg == S_IDEC)
            dt_reg <= dt_i;
        if (state_reg == S_STALE1)
            prod_reg <= 36'(stale_reg) * 36'(US_PER_S);
    end

    // stored level, volume, references and rings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            volume_reg    <= '0;
            oref_vol_reg  <= '0;
            iref_vol_reg  <= '0;
            oref_time_reg <= '0;
            iref_time_reg <= '0;
            opush_reg     <= '0;
            ipush_reg     <= '0;
            oslot_reg     <= '0;
            islot_reg     <= '0;
            osum_reg      <= '0;
            isum_reg      <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                oring_reg[i] <= '0;
                iring_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_MM && ar_done && !(|mm_q[27:16])
                && mm_q[15:0] <= max_reg)
                level_reg <= mm_q[15:0];
            if (state_reg == S_VQ && ar_done)
                volume_reg <= vol_sat;
            if (state_reg == S_ODEC)
            begin
                oref_vol_reg  <= vol_reg;
                oref_time_reg <= now_reg;
            end
            if (state_reg == S_IDEC)
            begin
                iref_vol_reg  <= vol_reg;
                iref_time_reg <= now_reg;
            end
            // running sums replace the old entry by the new one
            if (push_o)
            begin
                oring_reg[oslot_reg] <= pval_o;
                osum_reg  <= osum_reg - SUM_W'(oring_reg[oslot_reg]) + SUM_W'(pval_o);
                oslot_reg <= (oslot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 :
                             oslot_reg + SLOT_W'(1);
                opush_reg <= now_reg;
            end
            if (push_i)
            begin
                iring_reg[islot_reg] <= pval_i;
                isum_reg  <= isum_reg - SUM_W'(iring_reg[islot_reg]) + SUM_W'(pval_i);
                islot_reg <= (islot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 :
                             islot_reg + SLOT_W'(1);
                ipush_reg <= now_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (state_reg == S_DONE && (!ovalid_reg || !out_stall))
            ovalid_reg <= 1'b1;
        else if (!out_stall)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!ovalid_reg || !out_stall))
        begin
            ostatus_reg <= st_reg;
            olevel_reg  <= level_reg;
            ovolume_reg <= volume_reg;
            oavg_o_reg  <= 24'(osum_reg / RING_DEPTH);
            oavg_i_reg  <= 24'(isum_reg / RING_DEPTH);
        end
    end

    assign out_valid        = ovalid_reg;
    assign status           = ostatus_reg;
    assign level_mm         = olevel_reg;
    assign volume_l         = ovolume_reg;
    assign avg_outflow_clph = oavg_o_reg;
    assign avg_inflow_clph  = oavg_i_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        oslot_reg <= SLOT_W'(RING_DEPTH - 1) && islot_reg <= SLOT_W'(RING_DEPTH - 1))
        else $error("ring slot out of range");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        osum_reg <= SUM_W'(RING_DEPTH) * SUM_W'(RATE_MAX)
        && isum_reg <= SUM_W'(RING_DEPTH) * SUM_W'(RATE_MAX))
        else $error("ring sum beyond bound");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction left no work");
    a_tick_no_arith: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg && state_reg != S_IDLE) |-> !ar_req.start)
        else $error("tick used the shared unit");

endmodule
